@@ rtl/core/bif_pkg.sv @@
`default_nettype none

package bif_pkg;

  // stream counter width (slot and offset counters wrap at this width)
  localparam int COUNT_BITS = 16;

  // decoupling queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

  typedef logic [COUNT_BITS-1:0] count_t;

  typedef enum logic [2:0] {
    KIND_PLAIN = 3'd0,
    KIND_PUSH  = 3'd1,
    KIND_JNZ   = 3'd2,
    KIND_JZ    = 3'd3,
    KIND_CALL  = 3'd4
  } kind_t;

  // opcode pair bytes of the multi-byte forms
  localparam logic [7:0] OP_PUSH_A = 8'h01;
  localparam logic [7:0] OP_PUSH_B = 8'h04;
  localparam logic [7:0] OP_JUMP_A = 8'h04;
  localparam logic [7:0] OP_JNZ_B  = 8'hFD;
  localparam logic [7:0] OP_JZ_B   = 8'hFC;
  localparam logic [7:0] OP_CALL_A = 8'h0E;
  localparam logic [7:0] OP_CALL_B = 8'h01;

  // form lengths in bytes
  localparam logic [2:0] LEN_PLAIN = 3'd2;
  localparam logic [2:0] LEN_PUSH  = 3'd6;
  localparam logic [2:0] LEN_OTHER = 3'd4;

  // one queue request: either a complete instruction or an end-of-stream flush
  typedef struct packed {
    logic            flush;
    kind_t           kind;
    count_t          slot;
    count_t          offset;
    logic [5:0][7:0] bytes;
    logic [2:0]      byte_count;
    logic [1:0]      pair_count;
  } frame_t;

  function automatic kind_t pair_kind(input logic [7:0] a, input logic [7:0] b);
    kind_t k;
    priority if (a == OP_PUSH_A && b == OP_PUSH_B) k = KIND_PUSH;
    else if (a == OP_JUMP_A && b == OP_JNZ_B) k = KIND_JNZ;
    else if (a == OP_JUMP_A && b == OP_JZ_B) k = KIND_JZ;
    else if (a == OP_CALL_A && b == OP_CALL_B) k = KIND_CALL;
    else k = KIND_PLAIN;
    return k;
  endfunction

  function automatic logic [2:0] form_len(input kind_t k);
    logic [2:0] n;
    unique case (k)
      KIND_PLAIN: n = LEN_PLAIN;
      KIND_PUSH:  n = LEN_PUSH;
      default:    n = LEN_OTHER;
    endcase
    return n;
  endfunction

  function automatic logic [1:0] form_slots(input kind_t k);
    logic [1:0] n;
    unique case (k)
      KIND_PLAIN: n = 2'd1;
      KIND_PUSH:  n = 2'd3;
      default:    n = 2'd2;
    endcase
    return n;
  endfunction

  function automatic logic [15:0] low16(input count_t v);
    logic [31:0] w;
    w = 32'(v);
    return w[15:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/bif_front.sv @@
`default_nettype none

module bif_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic [7:0]      data_byte,
  input  wire logic            end_of_stream,
  output bif_pkg::frame_t      push_data,
  output logic                 push
);

  logic [5:0][7:0]  held_bytes;
  logic [5:0][7:0]  merged;
  logic [2:0]       held_count;
  logic [2:0]       held_count_next;
  logic [2:0]       new_count;
  logic [2:0]       need;
  bif_pkg::count_t  offset_counter;
  bif_pkg::count_t  offset_counter_next;
  bif_pkg::count_t  slot_counter;
  bif_pkg::count_t  slot_counter_next;
  bif_pkg::kind_t   k;
  logic             complete;

  always_comb begin
    merged = held_bytes;
    merged[held_count] = data_byte;
    new_count = held_count + 3'd1;
    k = bif_pkg::pair_kind(merged[0], merged[1]);
    need = bif_pkg::form_len(k);
    complete = (new_count >= 3'd2) && (new_count == need);

    push = accept && (complete || end_of_stream);
    push_data.flush      = !complete;
    push_data.kind       = complete ? k : bif_pkg::KIND_PLAIN;
    push_data.slot       = slot_counter;
    push_data.offset     = offset_counter;
    push_data.bytes      = merged;
    push_data.byte_count = new_count;
    push_data.pair_count = 2'((4'(new_count) + 4'd1) >> 1);

    held_count_next     = held_count;
    offset_counter_next = offset_counter;
    slot_counter_next   = slot_counter;
    if (accept) begin
      if (end_of_stream) begin
        held_count_next     = '0;
        offset_counter_next = '0;
        slot_counter_next   = '0;
      end else if (complete) begin
        held_count_next     = '0;
        offset_counter_next = offset_counter + bif_pkg::count_t'(need);
        slot_counter_next   = slot_counter + bif_pkg::count_t'(bif_pkg::form_slots(k));
      end else begin
        held_count_next = new_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count     <= '0;
      offset_counter <= '0;
      slot_counter   <= '0;
    end else begin
      held_count     <= held_count_next;
      offset_counter <= offset_counter_next;
      slot_counter   <= slot_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_bytes[held_count] <= data_byte;
    end
  end

`ifndef SYNTHESIS
  // an incomplete form never holds more than five bytes
  a_held_range: assert property (@(posedge clk) disable iff (rst)
    held_count <= 3'd5)
    else $error("held byte count out of range");

  // end of stream restarts the stream
  a_eos_restart: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_stream |=> held_count == '0 && slot_counter == '0 &&
                                offset_counter == '0)
    else $error("counters not cleared after end of stream");
`endif

endmodule

`default_nettype wire

@@ rtl/core/bif_queue.sv @@
`default_nettype none

module bif_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire bif_pkg::frame_t push_data,
  output logic                 full,
  input  wire logic            pop,
  output bif_pkg::frame_t      pop_data,
  output logic                 not_empty
);

  bif_pkg::frame_t                 entries [bif_pkg::QUEUE_DEPTH];
  logic [bif_pkg::QPTR_BITS-1:0]   wr_ptr;
  logic [bif_pkg::QPTR_BITS-1:0]   rd_ptr;
  logic [bif_pkg::QPTR_BITS:0]     fill;

  assign full      = fill == (bif_pkg::QPTR_BITS+1)'(bif_pkg::QUEUE_DEPTH);
  assign not_empty = fill != '0;
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("request pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

@@ rtl/core/bif_back.sv @@
`default_nettype none

module bif_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire bif_pkg::frame_t     head,
  input  wire logic                head_valid,
  output logic                     pop,
  output logic                     result_valid,
  input  wire logic                result_ready,
  output logic [2:0]               kind,
  output logic [15:0]              slot_index,
  output logic [15:0]              byte_offset,
  output logic [7:0]               opcode_byte,
  output logic [7:0]               sub_byte,
  output logic signed [31:0]       immediate,
  output logic [15:0]              jump_slot,
  output logic [16:0]              jump_byte,
  output logic [7:0]               library_id,
  output logic [7:0]               function_id,
  output logic                     last_of_run
);

  logic [1:0]   pair_idx;
  logic [1:0]   pair_idx_next;
  logic [2:0]   base;
  logic [2:0]   base_hi;
  logic         load;
  logic         last_pair;
  logic [15:0]  jslot;
  logic         is_jump;

  always_comb begin
    load      = head_valid && (!result_valid || result_ready);
    last_pair = !head.flush || (pair_idx == head.pair_count - 2'd1);
    pop       = load && last_pair;
    base      = {pair_idx, 1'b0};
    base_hi   = base + 3'd1;
    is_jump   = head.kind == bif_pkg::KIND_JNZ || head.kind == bif_pkg::KIND_JZ;
    jslot     = is_jump ? {head.bytes[3], head.bytes[2]} : 16'd0;
    pair_idx_next = pair_idx;
    if (load) begin
      pair_idx_next = last_pair ? 2'd0 : pair_idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      pair_idx     <= '0;
    end else begin
      pair_idx <= pair_idx_next;
      if (load) result_valid <= 1'b1;
      else if (result_ready) result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind        <= head.kind;
      slot_index  <= bif_pkg::low16(head.slot + bif_pkg::count_t'(pair_idx));
      byte_offset <= bif_pkg::low16(head.offset + bif_pkg::count_t'(base));
      opcode_byte <= head.bytes[base];
      sub_byte    <= (base_hi < head.byte_count) ? head.bytes[base_hi] : 8'd0;
      immediate   <= (head.kind == bif_pkg::KIND_PUSH) ?
                     {head.bytes[5], head.bytes[4], head.bytes[3], head.bytes[2]} : 32'sd0;
      jump_slot   <= jslot;
      jump_byte   <= {jslot, 1'b0};
      library_id  <= (head.kind == bif_pkg::KIND_CALL) ? head.bytes[2] : 8'd0;
      function_id <= (head.kind == bif_pkg::KIND_CALL) ? head.bytes[3] : 8'd0;
      last_of_run <= last_pair;
    end
  end

`ifndef SYNTHESIS
  // flush expansion stays within the pairs of the request
  a_pair_range: assert property (@(posedge clk) disable iff (rst)
    head_valid && head.flush |-> pair_idx < head.pair_count)
    else $error("pair index past end of flush request");

  a_pair_idle: assert property (@(posedge clk) disable iff (rst)
    !head_valid |-> pair_idx == 2'd0)
    else $error("pair index left over with empty queue");
`endif

endmodule

`default_nettype wire

@@ rtl/core/bytecode_instruction_framer_top.sv @@
// A byte that completes an instruction is written into the queue at its accepting edge; the back
// then loads it from the queue into the output register and raises result_valid.
// Throughput: one byte per cycle; the front takes a byte whenever the 4-entry queue has room.
// An end-of-stream flush of k pairs gives k results in the output register, one per pair (k up to 3).
// Reset (rst, synchronous, active high) clears held count, counters, queue pointers and
// result_valid; held bytes and result payload are not cleared.
`default_nettype none

module bytecode_instruction_framer_top (
  input  wire logic         clk,
  input  wire logic         rst,
  // byte stream in
  input  wire logic         byte_valid,
  output logic              byte_ready,
  input  wire logic [7:0]   data_byte,
  input  wire logic         end_of_stream,
  // decoded instructions out
  output logic              result_valid,
  input  wire logic         result_ready,
  output logic [2:0]        kind,
  output logic [15:0]       slot_index,
  output logic [15:0]       byte_offset,
  output logic [7:0]        opcode_byte,
  output logic [7:0]        sub_byte,
  output logic signed [31:0] immediate,
  output logic [15:0]       jump_slot,
  output logic [16:0]       jump_byte,
  output logic [7:0]        library_id,
  output logic [7:0]        function_id,
  output logic              last_of_run
);

  // Front: gathers bytes, recognizes the form from the opcode pair and pushes
  // one request per completed instruction, or one flush request when the end-of-stream byte completes none.
  // Queue: decouples the front from the output so the front keeps taking
  // bytes while the output is stalled or expanding a flush.
  // Back: turns each request into results in the output register, one per cycle unless stalled.

  logic             accept;
  logic             push;
  logic             pop;
  logic             full;
  logic             not_empty;
  bif_pkg::frame_t  push_data;
  bif_pkg::frame_t  head;

  assign byte_ready = !full;
  assign accept     = byte_valid && byte_ready;

  bif_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .push_data     (push_data),
    .push          (push)
  );

  bif_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (head),
    .not_empty (not_empty)
  );

  bif_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (not_empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .kind         (kind),
    .slot_index   (slot_index),
    .byte_offset  (byte_offset),
    .opcode_byte  (opcode_byte),
    .sub_byte     (sub_byte),
    .immediate    (immediate),
    .jump_slot    (jump_slot),
    .jump_byte    (jump_byte),
    .library_id   (library_id),
    .function_id  (function_id),
    .last_of_run  (last_of_run)
  );

endmodule

`default_nettype wire
